[rtl/core/psd_pkg.sv]
// Package for the point to segment distance pipeline.
// Holds the shared widths and the case select type; no dependencies.
package psd_pkg;

    localparam int CoordW = 16;
    localparam int DiffW  = 17;
    localparam int SqW    = 35;
    localparam int TW     = 16;
    localparam int OffW   = 42;
    localparam int MagW   = 26;
    localparam int RadW   = 52;
    localparam int RootW  = 26;
    localparam int DistW  = 17;

    typedef enum logic [1:0]
    {
        SEL_START = 2'd0,
        SEL_END   = 2'd1,
        SEL_PROJ  = 2'd2
    } sel_t;

endpackage

[rtl/core/psd_isqrt.sv]
// Pipelined integer square root, two result bits per stage.
// Depends on psd_pkg for the radicand and root widths.
module psd_isqrt
    import psd_pkg::*;
#(
    parameter int TagW = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             in_valid,
    input  logic [RadW-1:0]  in_rad,
    input  logic [TagW-1:0]  in_tag,
    output logic             out_valid,
    output logic [RootW-1:0] out_root,
    output logic [TagW-1:0]  out_tag
);

    localparam int Steps  = RootW;
    localparam int PerSt  = 2;
    localparam int Stages = Steps / PerSt;

    logic [RadW-1:0]  rem_reg  [Stages+1];
    logic [RootW-1:0] root_reg [Stages+1];
    logic [RadW-1:0]  src_reg  [Stages+1];
    logic [TagW-1:0]  tag_reg  [Stages+1];
    logic             vld_reg  [Stages+1];

    always_comb
    begin
        rem_reg[0]  = '0;
        root_reg[0] = '0;
        src_reg[0]  = in_rad;
        tag_reg[0]  = in_tag;
        vld_reg[0]  = in_valid;
    end

    for (genvar s = 0; s < Stages; s++)
    begin : g_st
        logic [RadW-1:0]  rem_next;
        logic [RootW-1:0] root_next;
        logic [RadW-1:0]  r_q;
        logic [RootW-1:0] q_q;
        logic [RadW-1:0]  s_q;
        logic [TagW-1:0]  t_q;
        logic             v_q;

        // Restoring digit recurrence: bring down two radicand bits, try 4q+1.
        always_comb
        begin
            logic [RadW-1:0]  r;
            logic [RootW-1:0] q;
            logic [RadW-1:0]  trial;
            r = rem_reg[s];
            q = root_reg[s];
            for (int k = 0; k < PerSt; k++)
            begin
                r = {r[RadW-3:0],
                     src_reg[s][RadW-1-2*(s*PerSt+k)],
                     src_reg[s][RadW-2-2*(s*PerSt+k)]};
                trial = {{(RadW-RootW-2){1'b0}}, q, 2'b01};
                if (r >= trial)
                begin
                    r = r - trial;
                    q = {q[RootW-2:0], 1'b1};
                end
                else
                begin
                    q = {q[RootW-2:0], 1'b0};
                end
            end
            rem_next  = r;
            root_next = q;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_q <= 1'b0;
            end
            else if (advance)
            begin
                v_q <= vld_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                r_q <= rem_next;
                q_q <= root_next;
                s_q <= src_reg[s];
                t_q <= tag_reg[s];
            end
        end

        always_comb
        begin
            rem_reg[s+1]  = r_q;
            root_reg[s+1] = q_q;
            src_reg[s+1]  = s_q;
            tag_reg[s+1]  = t_q;
            vld_reg[s+1]  = v_q;
        end
    end

    assign out_valid = vld_reg[Stages];
    assign out_root  = root_reg[Stages];
    assign out_tag   = tag_reg[Stages];

endmodule

[rtl/core/psd_tdiv.sv]
// Pipelined restoring divider for t = floor(num * 2^16 / len2), two bits per stage.
// Depends on psd_pkg; carries the offset operands alongside.
module psd_tdiv
    import psd_pkg::*;
#(
    parameter int TagW = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             in_valid,
    input  logic [SqW-1:0]   in_num,
    input  logic [SqW-1:0]   in_den,
    input  logic [TagW-1:0]  in_tag,
    output logic             out_valid,
    output logic [TW-1:0]    out_t,
    output logic [TagW-1:0]  out_tag
);

    // Since 0 < num < den, the quotient fits in 16 bits; each stage takes two bits.
    localparam int PerSt  = 2;
    localparam int Stages = TW / PerSt;

    logic [SqW:0]    rem_reg [Stages+1];
    logic [SqW-1:0]  den_reg [Stages+1];
    logic [TW-1:0]   q_reg   [Stages+1];
    logic [TagW-1:0] tag_reg [Stages+1];
    logic            vld_reg [Stages+1];

    always_comb
    begin
        rem_reg[0] = {1'b0, in_num};
        den_reg[0] = in_den;
        q_reg[0]   = '0;
        tag_reg[0] = in_tag;
        vld_reg[0] = in_valid;
    end

    for (genvar s = 0; s < Stages; s++)
    begin : g_st
        logic [SqW:0]    rem_next;
        logic [TW-1:0]   q_next;
        logic [SqW:0]    r_q;
        logic [SqW-1:0]  d_q;
        logic [TW-1:0]   qq;
        logic [TagW-1:0] t_q;
        logic            v_q;

        always_comb
        begin
            logic [SqW+1:0] r2;
            logic [TW-1:0]  q;
            r2 = {1'b0, rem_reg[s]};
            q  = q_reg[s];
            for (int k = 0; k < PerSt; k++)
            begin
                r2 = {r2[SqW:0], 1'b0};
                if (r2 >= {2'b00, den_reg[s]})
                begin
                    r2 = r2 - {2'b00, den_reg[s]};
                    q  = {q[TW-2:0], 1'b1};
                end
                else
                begin
                    q  = {q[TW-2:0], 1'b0};
                end
            end
            rem_next = r2[SqW:0];
            q_next   = q;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_q <= 1'b0;
            end
            else if (advance)
            begin
                v_q <= vld_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                r_q <= rem_next;
                d_q <= den_reg[s];
                qq  <= q_next;
                t_q <= tag_reg[s];
            end
        end

        always_comb
        begin
            rem_reg[s+1] = r_q;
            den_reg[s+1] = d_q;
            q_reg[s+1]   = qq;
            tag_reg[s+1] = t_q;
            vld_reg[s+1] = v_q;
        end
    end

    assign out_valid = vld_reg[Stages];
    assign out_t     = q_reg[Stages];
    assign out_tag   = tag_reg[Stages];

endmodule

[rtl/core/point_segment_distance.sv]
// Top level of the 2-D point to segment distance pipeline.
// Depends on psd_pkg, psd_tdiv and psd_isqrt.
//
// One item is accepted per clock and one distance leaves per clock when the
// output side is ready. Two stages form the differences and the squared
// length and dot product, eight stages of the projection divider find t two
// bits at a time, two stages form and square the offsets, thirteen stages of
// the square root find two root bits each, then the output register. The
// whole pipe stalls as one when a finished distance is waiting.
module point_segment_distance
    import psd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [CoordW-1:0] point_x,
    input  logic signed [CoordW-1:0] point_y,
    input  logic signed [CoordW-1:0] start_x,
    input  logic signed [CoordW-1:0] start_y,
    input  logic signed [CoordW-1:0] end_x,
    input  logic signed [CoordW-1:0] end_y,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [DistW-1:0]         distance
);

    // Payload carried through the divider.
    typedef struct packed {
        sel_t                    sel;
        logic signed [DiffW-1:0] rx;
        logic signed [DiffW-1:0] ry;
        logic signed [DiffW-1:0] dx;
        logic signed [DiffW-1:0] dy;
        logic signed [DiffW-1:0] qx;
        logic signed [DiffW-1:0] qy;
    } geo_t;

    localparam int GeoW = $bits(geo_t);

    logic advance;
    logic out_valid_reg;
    logic [DistW-1:0] distance_reg;

    // The pipe moves whenever the output register is free or being emptied.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // Stage 1: differences.
    logic v1_reg;
    logic signed [DiffW-1:0] rx1_reg, ry1_reg, dx1_reg, dy1_reg, qx1_reg, qy1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rx1_reg <= DiffW'(point_x) - DiffW'(start_x);
            ry1_reg <= DiffW'(point_y) - DiffW'(start_y);
            dx1_reg <= DiffW'(end_x) - DiffW'(start_x);
            dy1_reg <= DiffW'(end_y) - DiffW'(start_y);
            qx1_reg <= DiffW'(point_x) - DiffW'(end_x);
            qy1_reg <= DiffW'(point_y) - DiffW'(end_y);
        end
    end

    // Stage 2: squared length and dot product, then the case select.
    logic v2_reg;
    logic signed [SqW+1:0] len2_next, num_next;
    logic [SqW-1:0] len2_reg, num_reg;
    geo_t g2_reg, g2_next;

    always_comb
    begin
        len2_next = (SqW+2)'(dx1_reg * dx1_reg) + (SqW+2)'(dy1_reg * dy1_reg);
        num_next  = (SqW+2)'(rx1_reg * dx1_reg) + (SqW+2)'(ry1_reg * dy1_reg);
        g2_next.rx = rx1_reg;
        g2_next.ry = ry1_reg;
        g2_next.dx = dx1_reg;
        g2_next.dy = dy1_reg;
        g2_next.qx = qx1_reg;
        g2_next.qy = qy1_reg;
        if (len2_next == '0 || num_next <= 0)
        begin
            g2_next.sel = SEL_START;
        end
        else if (num_next >= len2_next)
        begin
            g2_next.sel = SEL_END;
        end
        else
        begin
            g2_next.sel = SEL_PROJ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (advance)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            g2_reg <= g2_next;
            // Only the interior case reaches the divider with meaning; keep it non-zero.
            if (g2_next.sel == SEL_PROJ)
            begin
                len2_reg <= SqW'(len2_next);
                num_reg  <= SqW'(num_next);
            end
            else
            begin
                len2_reg <= SqW'(1);
                num_reg  <= '0;
            end
        end
    end

    // Divider stages.
    logic         vd;
    logic [TW-1:0] t_d;
    logic [GeoW-1:0] gd_bits;
    geo_t gd;

    psd_tdiv #(.TagW(GeoW)) u_tdiv
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (v2_reg),
        .in_num    (num_reg),
        .in_den    (len2_reg),
        .in_tag    (g2_reg),
        .out_valid (vd),
        .out_t     (t_d),
        .out_tag   (gd_bits)
    );

    assign gd = geo_t'(gd_bits);

    // Offset stage: exact Q.16 offsets for the interior case, magnitudes to Q.8.
    logic v3_reg;
    sel_t sel3_reg;
    logic [MagW-1:0] mx3_reg, my3_reg;
    logic signed [OffW-1:0] ox, oy;
    logic [OffW-1:0] ax, ay;
    logic [DiffW-1:0] ex, ey;

    always_comb
    begin
        ox = (OffW'(gd.rx) <<< TW) - OffW'($signed({1'b0, t_d}) * gd.dx);
        oy = (OffW'(gd.ry) <<< TW) - OffW'($signed({1'b0, t_d}) * gd.dy);
        ax = ox[OffW-1] ? OffW'(-ox) : OffW'(ox);
        ay = oy[OffW-1] ? OffW'(-oy) : OffW'(oy);
        if (gd.sel == SEL_END)
        begin
            ex = gd.qx[DiffW-1] ? DiffW'(-gd.qx) : DiffW'(gd.qx);
            ey = gd.qy[DiffW-1] ? DiffW'(-gd.qy) : DiffW'(gd.qy);
        end
        else
        begin
            ex = gd.rx[DiffW-1] ? DiffW'(-gd.rx) : DiffW'(gd.rx);
            ey = gd.ry[DiffW-1] ? DiffW'(-gd.ry) : DiffW'(gd.ry);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v3_reg <= vd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sel3_reg <= gd.sel;
            if (gd.sel == SEL_PROJ)
            begin
                mx3_reg <= ax[MagW+7:8];
                my3_reg <= ay[MagW+7:8];
            end
            else
            begin
                mx3_reg <= MagW'(ex);
                my3_reg <= MagW'(ey);
            end
        end
    end

    // Square stage.
    logic v4_reg;
    logic proj4_reg;
    logic [RadW-1:0] rad4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            proj4_reg <= (sel3_reg == SEL_PROJ);
            rad4_reg  <= RadW'(mx3_reg * mx3_reg) + RadW'(my3_reg * my3_reg);
        end
    end

    logic            vs;
    logic [RootW-1:0] root_s;
    logic            proj_s;

    psd_isqrt #(.TagW(1)) u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (v4_reg),
        .in_rad    (rad4_reg),
        .in_tag    (proj4_reg),
        .out_valid (vs),
        .out_root  (root_s),
        .out_tag   (proj_s)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= vs;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            distance_reg <= proj_s ? DistW'(root_s >> 8) : DistW'(root_s);
        end
    end

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;

    // A waiting result must not change under a stall.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(distance))
        else $error("distance changed while stalled");

    // Input is taken exactly when the pipe moves.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow the output side");

    // The divider only sees a non-zero divisor.
    a_den: assert property (@(posedge clk) disable iff (!rst_n)
        len2_reg != '0)
        else $error("zero divisor entered the divider");

endmodule
